// ===== rtl/biquad_df2t_filter_macros.svh =====
// Assertion macros for the biquad filter.
// No dependencies; included by the top level only.
`ifndef BIQUAD_DF2T_FILTER_MACROS_SVH
`define BIQUAD_DF2T_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BQD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BQD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bqd_pkg.sv =====
// Shared types, register indexes and the microprogram of the biquad filter.
// No dependencies.
package bqd_pkg;

    localparam int COEF_BITS    = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int STEP_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_NO_INPUT = 2'd1,
        COND_OUT_FULL = 2'd2
    } cond_t;

    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic {
        MUL_X = 1'b0,
        MUL_Y = 1'b1
    } mul_src_t;

    typedef enum logic [1:0] {
        ADD_D1   = 2'd0,
        ADD_D2   = 2'd1,
        ADD_ACC  = 2'd2,
        ADD_ZERO = 2'd3
    } add_src_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coefs_t;

    typedef struct packed {
        cond_t                 cond;
        logic [STEP_BITS-1:0]  target;
        logic                  in_ready;
        logic                  mul_en;
        coef_sel_t             coef_sel;
        mul_src_t              mul_src;
        add_src_t              add_src;
        logic                  add_neg;
        logic                  acc_we;
        logic                  d1_we;
        logic                  d2_we;
        logic                  y_we;
        logic                  emit;
    } ctrl_t;

    // Microprogram. When a step's jump is taken, its writes are dropped by the sequencer.
    function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
        ctrl_t cw;
        cw = '0;
        cw.cond     = COND_NONE;
        cw.coef_sel = COEF_B0;
        cw.mul_src  = MUL_X;
        cw.add_src  = ADD_ZERO;
        unique case (step)
            3'd0: begin // wait for a sample beat
                cw.cond     = COND_NO_INPUT;
                cw.target   = 3'd0;
                cw.in_ready = 1'b1;
            end
            3'd1: begin // p = b0*x
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_B0;
            end
            3'd2: begin // acc = sat(p + d1); p = b1*x
                cw.add_src  = ADD_D1;
                cw.acc_we   = 1'b1;
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_B1;
            end
            3'd3: begin // y = round(acc); acc = sat(p + d2)
                cw.y_we     = 1'b1;
                cw.add_src  = ADD_D2;
                cw.acc_we   = 1'b1;
            end
            3'd4: begin // p = a1*y
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_A1;
                cw.mul_src  = MUL_Y;
            end
            3'd5: begin // d1 = sat(acc - p); p = b2*x
                cw.add_src  = ADD_ACC;
                cw.add_neg  = 1'b1;
                cw.d1_we    = 1'b1;
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_B2;
            end
            3'd6: begin // acc = p; p = a2*y
                cw.add_src  = ADD_ZERO;
                cw.acc_we   = 1'b1;
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_A2;
                cw.mul_src  = MUL_Y;
            end
            3'd7: begin // d2 = sat(acc - p); emit, hold while output is full
                cw.cond     = COND_OUT_FULL;
                cw.target   = 3'd7;
                cw.add_src  = ADD_ACC;
                cw.add_neg  = 1'b1;
                cw.d2_we    = 1'b1;
                cw.emit     = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/bqd_sequencer.sv =====
// Step counter and microprogram fetch for the biquad filter.
// Depends on bqd_pkg (control word and program table).
module bqd_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           out_busy,
    output bqd_pkg::ctrl_t ctrl
);
    import bqd_pkg::*;

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    ctrl_t                cw;
    logic                 taken;

    assign cw = ucode(step_reg);

    always_comb begin
        unique case (cw.cond)
            COND_NONE:     taken = 1'b0;
            COND_NO_INPUT: taken = !in_valid;
            COND_OUT_FULL: taken = out_busy;
            default:       taken = 1'b0;
        endcase
    end

    // last step wraps to zero through the counter overflow
    assign step_next = taken ? cw.target : step_reg + 1'b1;

    always_comb begin
        ctrl = cw;
        if (taken) begin
            ctrl.mul_en = 1'b0;
            ctrl.acc_we = 1'b0;
            ctrl.d1_we  = 1'b0;
            ctrl.d2_we  = 1'b0;
            ctrl.y_we   = 1'b0;
            ctrl.emit   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/bqd_datapath.sv =====
// Shared multiplier, saturating adder, rounding and filter state.
// Depends on bqd_pkg (control word, coefficient bundle).
module bqd_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bqd_pkg::ctrl_t                ctrl,
    input  bqd_pkg::coefs_t               coefs,
    input  logic                          load_x,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    output logic signed [SAMPLE_BITS-1:0] y_out
);
    import bqd_pkg::*;

    localparam int STATE_BITS = SAMPLE_BITS + 32;
    localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_BITS   = STATE_BITS + 2;
    localparam int Y_WIDE     = STATE_BITS - COEF_FRAC_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [STATE_BITS-1:0]  acc_reg;
    logic signed [STATE_BITS-1:0]  d1_reg;
    logic signed [STATE_BITS-1:0]  d2_reg;
    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [STATE_BITS-1:0]  addend;
    logic signed [SUM_BITS-1:0]    term;
    logic signed [SUM_BITS-1:0]    sum;
    logic [SUM_BITS-STATE_BITS:0]  sum_hi;
    logic signed [STATE_BITS-1:0]  sum_sat;
    logic [Y_WIDE-1:0]             y_wide;
    logic [Y_WIDE-SAMPLE_BITS:0]   y_hi;

    always_comb begin
        unique case (ctrl.coef_sel)
            COEF_B0: mul_a = coefs.b0;
            COEF_B1: mul_a = coefs.b1;
            COEF_B2: mul_a = coefs.b2;
            COEF_A1: mul_a = coefs.a1;
            COEF_A2: mul_a = coefs.a2;
            default: mul_a = coefs.b0;
        endcase
    end

    assign mul_b     = (ctrl.mul_src == MUL_Y) ? y_reg : x_reg;
    assign prod_next = mul_a * mul_b;

    always_comb begin
        unique case (ctrl.add_src)
            ADD_D1:   addend = d1_reg;
            ADD_D2:   addend = d2_reg;
            ADD_ACC:  addend = acc_reg;
            ADD_ZERO: addend = '0;
            default:  addend = '0;
        endcase
    end

    assign term   = ctrl.add_neg ? -SUM_BITS'(prod_reg) : SUM_BITS'(prod_reg);
    assign sum    = SUM_BITS'(addend) + term;
    assign sum_hi = sum[SUM_BITS-1:STATE_BITS-1];

    always_comb begin
        if ((&sum_hi) || !(|sum_hi)) begin
            sum_sat = sum[STATE_BITS-1:0];
        end else if (sum[SUM_BITS-1]) begin
            sum_sat = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    end

    // round half up: floor(acc / 2^F) plus the first dropped bit
    assign y_wide = {acc_reg[STATE_BITS-1], acc_reg[STATE_BITS-1:COEF_FRAC_BITS]}
                  + {{(Y_WIDE-1){1'b0}}, acc_reg[COEF_FRAC_BITS-1]};
    assign y_hi   = y_wide[Y_WIDE-1:SAMPLE_BITS-1];

    always_comb begin
        if ((&y_hi) || !(|y_hi)) begin
            y_next = y_wide[SAMPLE_BITS-1:0];
        end else if (y_wide[Y_WIDE-1]) begin
            y_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (load_x) begin
            x_reg <= x_in;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctrl.acc_we) begin
            acc_reg <= sum_sat;
        end
        if (ctrl.y_we) begin
            y_reg <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else begin
            if (ctrl.d1_we) begin
                d1_reg <= sum_sat;
            end
            if (ctrl.d2_we) begin
                d2_reg <= sum_sat;
            end
        end
    end

    assign y_out = y_reg;

endmodule

// ===== rtl/biquad_df2t_filter.sv =====
// Biquad IIR filter, direct form II transposed, one shared 32 x SAMPLE_BITS multiplier.
// A new sample is taken only once the eight-step microprogram around the multiplier has finished the last one.
// The emit in the last program step loads the output register and marks the result beat valid.
// The result sits in an output register; the program waits in its last step while it is full.
// Reset: coefficients to b0 = 1.0 and others 0, both state accumulators to 0, output empty.
// Depends on bqd_pkg, bqd_sequencer, bqd_datapath and the assertion macro header.
`include "biquad_df2t_filter_macros.svh"

module biquad_df2t_filter #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bqd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bqd_pkg::COEF_BITS-1:0]        cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,
    input  logic                                 s_block_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out,
    output logic                                 m_block_end_out
);
    import bqd_pkg::*;

    coefs_t                        coefs_reg;
    ctrl_t                         ctrl;
    logic                          accept;
    logic                          out_busy;
    logic                          flag_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic                          m_flag_reg;
    logic signed [SAMPLE_BITS-1:0] y;

    assign cfg_ready = 1'b1;
    assign s_ready   = ctrl.in_ready;
    assign accept    = s_valid && s_ready;
    assign out_busy  = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.b0 <= COEF_BITS'(1) << COEF_FRAC_BITS;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_B0:  coefs_reg.b0 <= cfg_data;
                REG_B1:  coefs_reg.b1 <= cfg_data;
                REG_B2:  coefs_reg.b2 <= cfg_data;
                REG_A1:  coefs_reg.a1 <= cfg_data;
                REG_A2:  coefs_reg.a2 <= cfg_data;
                default: ; // unknown index: dropped
            endcase
        end
    end

    bqd_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    bqd_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .coefs   (coefs_reg),
        .load_x  (accept),
        .x_in    (s_sample_in),
        .y_out   (y)
    );

    always_comb begin
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            flag_reg <= s_block_end;
        end
        if (ctrl.emit) begin
            m_sample_reg <= y;
            m_flag_reg   <= flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample_out    = m_sample_reg;
    assign m_block_end_out = m_flag_reg;

    `BQD_ASSERT_IMPLY(a_emit_no_overwrite, aclk, aresetn, ctrl.emit, !out_busy, "overwrite")
    `BQD_ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_ready, "sample taken while busy")
    `BQD_ASSERT_IMPLY(a_valid_src, aclk, aresetn, $rose(m_valid), $past(ctrl.emit), "stray valid")

endmodule
